// ===== hw/rtl/rrva_pkg.sv =====
`timescale 1ns / 1ps

package rrva_pkg;

   localparam int DEF_NUM_CHANNELS = 8;
   localparam int DEF_FLIT_WIDTH   = 32;
   localparam int CFG_W            = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   typedef enum logic [2:0] {
      CMD_REQUEST    = 3'd0,
      CMD_PICK       = 3'd1,
      CMD_PICK_READY = 3'd2,
      CMD_PULL       = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_NO_WINNER = 2'd1,
      ERR_PULL_IDLE = 2'd2,
      ERR_RANGE     = 2'd3
   } err_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  channel;
      logic [31:0] flit_in;
      logic [7:0]  ready_mask;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  winner;
      logic        winner_valid;
      logic [31:0] flit_out;
      logic        channel_pending;
      logic        none_pending;
      logic        none_pending_ready;
      logic [1:0]  error;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
      logic cfg_write;
   } ctl_cmd_type;

endpackage

// ===== hw/rtl/round_robin_vc_arbiter_top.sv =====
// Round-robin arbiter over virtual channels. Each transfer on the req_ channel carries one
// command (request, pick, pick under the ready mask, pull, clear), and each produces exactly
// one transfer on the rsp_ channel. An item passes an execute state, which runs the command
// on the pending vector, the wrap-around priority search from the channel after the last
// winner and, for a pull, the read of the flit store, and a finish state, which waits for
// room, loads the result register and may already accept the next item. The registered flit
// read is why the load waits for the finish state. A result waiting in the output register
// still lets the next item be taken and executed; that item then holds in its finish state,
// with the input closed, until the waiting result is taken. The channel count register on
// the csr_ port is taken only while the block is idle; writing it drops all pending requests
// and the held grant, while stored flits are kept. No clearing pass runs after reset.
`timescale 1ns / 1ps

module round_robin_vc_arbiter_top #(
   parameter int NUM_CHANNELS = rrva_pkg::DEF_NUM_CHANNELS,
   parameter int FLIT_WIDTH   = rrva_pkg::DEF_FLIT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rrva_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rrva_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rrva_pkg::CFG_W-1:0] csr_data
);
   import rrva_pkg::*;

   ctl_cmd_type ctl;

   rrva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .ctl       (ctl)
   );

   rrva_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .FLIT_WIDTH   (FLIT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_payload (req_payload),
      .csr_data    (csr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/rrva_ram.sv =====
`timescale 1ns / 1ps

module rrva_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rrva_ctrl.sv =====
`timescale 1ns / 1ps

module rrva_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   output rrva_pkg::ctl_cmd_type ctl
);
   import rrva_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      state_in      = state_ff;
      req_ready     = 1'b0;
      csr_ready     = 1'b0;
      ctl.execute   = 1'b0;
      ctl.load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.execute = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               ctl.load  = 1'b1;
               req_ready = 1'b1;
               state_in  = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ctl.capture   = req_valid && req_ready;
      ctl.cfg_write = csr_valid && csr_ready;
      rsp_valid_in  = ctl.load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result register loaded while still full.");

   a_exec_then_finish: assert property (@(posedge clock) disable iff (reset)
      ctl.execute |=> (state_ff == ST_FINISH))
      else $error("Execute cycle not followed by the finish cycle.");

   a_capture_starts_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> ctl.execute)
      else $error("Accepted item did not start executing.");

endmodule

// ===== hw/rtl/rrva_datapath.sv =====
`timescale 1ns / 1ps

module rrva_datapath #(
   parameter int NUM_CHANNELS = rrva_pkg::DEF_NUM_CHANNELS,
   parameter int FLIT_WIDTH   = rrva_pkg::DEF_FLIT_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rrva_pkg::ctl_cmd_type      ctl,
   input  rrva_pkg::req_payload_type  req_payload,
   input  logic [rrva_pkg::CFG_W-1:0] csr_data,
   output rrva_pkg::rsp_payload_type  rsp_payload
);
   import rrva_pkg::*;

   localparam int IDX_W = $clog2(NUM_CHANNELS);

   req_payload_type         req_ff;
   rsp_payload_type         rsp_ff, rsp_in;
   logic [CFG_W-1:0]        cfg_ff;
   logic [NUM_CHANNELS-1:0] pending_ff, pending_in;
   logic [IDX_W-1:0]        last_grant_ff, last_grant_in;
   logic                    grant_held_ff, grant_held_in;
   logic                    valid_ff, valid_in;
   err_type                 err_ff, err_in;
   logic                    pull_ok_ff, pull_ok_in;

   logic [CFG_W-1:0]          active_n;
   logic [NUM_CHANNELS-1:0]   in_use;
   logic [NUM_CHANNELS+7:0]   ready_wide;
   logic [NUM_CHANNELS-1:0]   ready_vec;
   logic [NUM_CHANNELS-1:0]   elig;
   logic [NUM_CHANNELS-1:0]   above;
   logic [NUM_CHANNELS-1:0]   elig_above;
   logic [IDX_W-1:0]          found_idx;
   logic                      found;
   logic [IDX_W-1:0]          win_idx;
   logic [IDX_W-1:0]          chan_idx;
   logic                      chan_in_range;
   logic                      use_ready;
   logic                      ram_we;
   logic                      ram_re;
   logic [FLIT_WIDTH-1:0]     ram_rdata;

   always_comb begin
      if (cfg_ff == '0) begin
         active_n = CFG_W'(1);
      end else if (int'(cfg_ff) > NUM_CHANNELS) begin
         active_n = CFG_W'(NUM_CHANNELS);
      end else begin
         active_n = cfg_ff;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         in_use[i] = i < int'(active_n);
         above[i]  = i > int'(last_grant_ff);
      end
   end

   assign ready_wide    = {{NUM_CHANNELS{1'b0}}, req_ff.ready_mask};
   assign ready_vec     = ready_wide[NUM_CHANNELS-1:0];
   assign chan_idx      = IDX_W'(req_ff.channel);
   assign chan_in_range = CFG_W'(req_ff.channel) < active_n;
   assign use_ready     = req_ff.command == CMD_PICK_READY;
   assign elig          = pending_ff & in_use & (use_ready ? ready_vec : '1);
   assign elig_above    = elig & above;
   assign found         = |elig;

   always_comb begin
      found_idx = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (elig[i]) begin
            found_idx = IDX_W'(i);
         end
      end
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (elig_above[i]) begin
            found_idx = IDX_W'(i);
         end
      end
   end

   assign win_idx = grant_held_ff ? last_grant_ff : found_idx;

   always_comb begin
      pending_in    = pending_ff;
      last_grant_in = last_grant_ff;
      grant_held_in = grant_held_ff;
      valid_in      = valid_ff;
      err_in        = err_ff;
      pull_ok_in    = pull_ok_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      if (ctl.cfg_write) begin
         pending_in    = '0;
         last_grant_in = '0;
         grant_held_in = 1'b0;
      end else if (ctl.execute) begin
         valid_in   = 1'b0;
         err_in     = ERR_OK;
         pull_ok_in = 1'b0;
         unique case (req_ff.command)
            CMD_REQUEST: begin
               if (chan_in_range) begin
                  pending_in[chan_idx] = 1'b1;
                  ram_we               = 1'b1;
               end else begin
                  err_in = ERR_RANGE;
               end
               valid_in = grant_held_ff;
            end
            CMD_PICK, CMD_PICK_READY: begin
               if (grant_held_ff) begin
                  valid_in = 1'b1;
               end else if (found) begin
                  last_grant_in = found_idx;
                  grant_held_in = 1'b1;
                  valid_in      = 1'b1;
               end else begin
                  err_in = ERR_NO_WINNER;
               end
            end
            CMD_PULL: begin
               ram_re = 1'b1;
               if (!grant_held_ff && found) begin
                  last_grant_in = found_idx;
               end
               if ((grant_held_ff || found) && pending_ff[win_idx]) begin
                  pending_in[win_idx] = 1'b0;
                  valid_in            = 1'b1;
                  pull_ok_in          = 1'b1;
               end else begin
                  err_in = ERR_PULL_IDLE;
               end
               grant_held_in = 1'b0;
            end
            CMD_CLEAR: begin
               pending_in[last_grant_ff] = 1'b0;
               grant_held_in             = 1'b0;
            end
            default: begin
               valid_in = grant_held_ff;
            end
         endcase
      end
   end

   rrva_ram #(
      .WIDTH (FLIT_WIDTH),
      .DEPTH (NUM_CHANNELS)
   ) u_flit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (chan_idx),
      .wr_data (FLIT_WIDTH'(req_ff.flit_in)),
      .rd_en   (ram_re),
      .rd_addr (win_idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rsp_in.winner             = 3'(last_grant_ff);
      rsp_in.winner_valid       = valid_ff;
      rsp_in.flit_out           = pull_ok_ff ? 32'(ram_rdata) : 32'd0;
      rsp_in.channel_pending    = chan_in_range && pending_ff[chan_idx];
      rsp_in.none_pending       = ~|pending_ff;
      rsp_in.none_pending_ready = ~|(pending_ff & ready_vec);
      rsp_in.error              = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         pending_ff    <= '0;
         last_grant_ff <= '0;
         grant_held_ff <= 1'b0;
      end else begin
         if (ctl.cfg_write) begin
            cfg_ff <= csr_data;
         end
         pending_ff    <= pending_in;
         last_grant_ff <= last_grant_in;
         grant_held_ff <= grant_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_payload;
      end
      if (ctl.load) begin
         rsp_ff <= rsp_in;
      end
      valid_ff   <= valid_in;
      err_ff     <= err_in;
      pull_ok_ff <= pull_ok_in;
   end

   assign rsp_payload = rsp_ff;

   a_grant_is_pending: assert property (@(posedge clock) disable iff (reset)
      grant_held_ff |-> pending_ff[last_grant_ff])
      else $error("A held grant points at a channel with no pending request.");

   a_grant_in_use: assert property (@(posedge clock) disable iff (reset)
      int'(last_grant_ff) < int'(active_n))
      else $error("Last grant lies outside the channels in use.");

   a_pending_in_use: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & ~in_use) == '0)
      else $error("A channel outside those in use has a pending request.");

endmodule
